FILE: sv/source_text_lexer_macros.svh
// assertion macros shared by the lexer checker
// depends on nothing; included by the checker file
`ifndef SOURCE_TEXT_LEXER_MACROS_SVH
`define SOURCE_TEXT_LEXER_MACROS_SVH

// same-cycle implication, disabled in reset
`define STX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// next-cycle implication, disabled in reset
`define STX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

FILE: sv/stx_pkg.sv
// shared types, token codes and keyword table of the source text lexer
// no dependencies
package stx_pkg;

    // token kinds
    localparam logic [4:0] K_PLUS    = 5'd0;
    localparam logic [4:0] K_MINUS   = 5'd1;
    localparam logic [4:0] K_STAR    = 5'd2;
    localparam logic [4:0] K_SLASH   = 5'd3;
    localparam logic [4:0] K_DOT     = 5'd4;
    localparam logic [4:0] K_COMMA   = 5'd5;
    localparam logic [4:0] K_SEMI    = 5'd6;
    localparam logic [4:0] K_GT      = 5'd7;
    localparam logic [4:0] K_GTEQ    = 5'd8;
    localparam logic [4:0] K_GT2     = 5'd9;
    localparam logic [4:0] K_LT      = 5'd10;
    localparam logic [4:0] K_LTEQ    = 5'd11;
    localparam logic [4:0] K_LT2     = 5'd12;
    localparam logic [4:0] K_EXC     = 5'd13;
    localparam logic [4:0] K_NEQ     = 5'd14;
    localparam logic [4:0] K_EQ      = 5'd15;
    localparam logic [4:0] K_EQ2     = 5'd16;
    localparam logic [4:0] K_NUMBER  = 5'd17;
    localparam logic [4:0] K_CHAR    = 5'd18;
    localparam logic [4:0] K_STRING  = 5'd19;
    localparam logic [4:0] K_KEYWORD0 = 5'd20;
    localparam logic [4:0] K_IDENT   = 5'd28;
    localparam logic [4:0] K_END     = 5'd29;

    // character codes
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_GT     = 8'h3E;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_EXC    = 8'h21;
    localparam logic [7:0] C_EQ     = 8'h3D;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_NL     = 8'h0A;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_NINE   = 8'h39;
    localparam logic [7:0] C_LA     = 8'h61;
    localparam logic [7:0] C_LZ     = 8'h7A;
    localparam logic [7:0] C_UA     = 8'h41;
    localparam logic [7:0] C_UZ     = 8'h5A;
    localparam logic [7:0] C_UNDER  = 8'h5F;
    localparam logic [7:0] C_LE     = 8'h65;
    localparam logic [7:0] C_UE     = 8'h45;

    // keyword text, first byte in the low bits, zero padded
    localparam int NUM_KW = 8;
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'h0000_6E72_7574_6572,   // return
        64'h0000_0000_636E_7566,   // func
        64'h0000_0000_0074_6567,   // get
        64'h0000_0000_0000_6669,   // if
        64'h0000_0000_6573_6C65,   // else
        64'h0000_0065_6C69_6877,   // while
        64'h0000_006B_6165_7262,   // break
        64'h6575_6E69_746E_6F63    // continue
    };
    localparam logic [15:0] KW_LEN [NUM_KW] = '{
        16'd6, 16'd4, 16'd3, 16'd2, 16'd4, 16'd5, 16'd5, 16'd8
    };

    // result queue depth
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [4:0]         kind;
        logic [15:0]        start;
        logic [15:0]        length;
        logic [63:0]        sig;
        logic signed [10:0] dexp;
        logic [7:0]         chv;
        logic               ovf;
        logic               last;
    } t_token;

    // up to two tokens produced by one byte
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic t_token mk_tok(input logic [4:0] kind, input logic [15:0] start);
        t_token t;
        t = '0;
        t.kind  = kind;
        t.start = start;
        return t;
    endfunction

    // keyword lookup on the first eight word bytes
    function automatic logic [4:0] kw_kind(input logic [63:0] bytes, input logic [15:0] cnt);
        logic [4:0] k;
        k = K_IDENT;
        for (int i = NUM_KW - 1; i >= 0; i--) begin
            if (cnt == KW_LEN[i] && bytes == KW_TEXT[i]) begin
                k = K_KEYWORD0 + 5'(i);
            end
        end
        return k;
    endfunction

endpackage

FILE: sv/stx_core.sv
// lexer core: input byte register, scan mode state and per-byte token logic
// depends on stx_pkg
module stx_core #(
    parameter int POSITION_BITS    = 16,
    parameter int SIGNIFICAND_BITS = 64,
    parameter int KEYWORD_BYTES    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_char_code,
    input  logic          i_final_source,
    input  logic          i_room,
    output stx_pkg::t_push o_push
);
    import stx_pkg::*;

    localparam int SB = SIGNIFICAND_BITS;
    localparam int PB = POSITION_BITS;

    typedef enum logic [3:0] {
        M_IDLE, M_PUNCT, M_COMMENT, M_IDENT, M_QUOTE,
        M_INT, M_FRAC, M_ESTART, M_ESIGN, M_EXP
    } t_mode;

    logic          r_in_vld, r_fin;
    logic [7:0]    r_c;
    t_mode         r_mode, n_mode;
    logic [7:0]    r_pend, n_pend;
    logic [PB-1:0] r_pos, n_pos;
    logic [PB-1:0] r_begin, n_begin;
    logic [7:0]    r_wb [KEYWORD_BYTES];
    logic [7:0]    n_wb [KEYWORD_BYTES];
    logic [15:0]   r_cnt, n_cnt;
    logic [SB-1:0] r_acc, n_acc;
    logic [7:0]    r_frac, n_frac;
    logic [10:0]   r_exp, n_exp;
    logic          r_neg, n_neg, r_qs, n_qs, r_sat, n_sat;
    logic [7:0]    r_first, n_first;

    logic            fire;
    logic            w_digit, w_alpha, w_space;
    logic [3:0]      w_d;
    logic [SB+3:0]   w_acc_wide;
    logic            w_acc_ovf;
    logic [SB-1:0]   w_acc_next;
    logic [14:0]     w_exp_wide;
    logic [10:0]     w_exp_next;
    logic signed [12:0] w_e, w_dx;
    logic [63:0]     w_kwbytes;
    t_token          ft;
    logic            ft_v;
    logic [4:0]      w_pair;
    t_push           push;
    logic [15:0]     w_cur16;

    assign fire       = r_in_vld & i_room;
    assign o_in_ready = ~r_in_vld | fire;
    assign w_cur16    = 16'(r_pos);

    // byte classes
    assign w_digit = (r_c >= C_ZERO) && (r_c <= C_NINE);
    assign w_alpha = ((r_c >= C_LA) && (r_c <= C_LZ)) || ((r_c >= C_UA) && (r_c <= C_UZ));
    assign w_space = (r_c == C_SPACE) || ((r_c >= C_TAB) && (r_c <= C_CR));
    assign w_d     = 4'(r_c - C_ZERO);

    // significand times ten plus digit, saturating
    assign w_acc_wide = ((SB+4)'(r_acc) << 3) + ((SB+4)'(r_acc) << 1) + (SB+4)'(w_d);
    assign w_acc_ovf  = |w_acc_wide[SB+3:SB];
    assign w_acc_next = w_acc_ovf ? '1 : w_acc_wide[SB-1:0];

    // exponent magnitude times ten plus digit, clamped
    assign w_exp_wide = (15'(r_exp) << 3) + (15'(r_exp) << 1) + 15'(w_d);
    assign w_exp_next = (w_exp_wide > 15'd2047) ? 11'h7FF : w_exp_wide[10:0];

    // decimal exponent before clamping
    assign w_e  = r_neg ? -$signed({2'b00, r_exp}) : $signed({2'b00, r_exp});
    assign w_dx = w_e - $signed({5'b0, r_frac});

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_kwbytes[8*k +: 8] = r_wb[k];
        end
    end

    // token held by the current mode
    always_comb begin
        ft   = '0;
        ft_v = 1'b0;
        case (r_mode)
            M_PUNCT: begin
                ft_v = 1'b1;
                ft   = mk_tok(K_EQ, 16'(r_begin));
                case (r_pend)
                    C_SLASH: ft.kind = K_SLASH;
                    C_DOT:   ft.kind = K_DOT;
                    C_GT:    ft.kind = K_GT;
                    C_LT:    ft.kind = K_LT;
                    C_EXC:   ft.kind = K_EXC;
                    default: ft.kind = K_EQ;
                endcase
            end
            M_IDENT: begin
                ft_v      = 1'b1;
                ft        = mk_tok(kw_kind(w_kwbytes, r_cnt), 16'(r_begin));
                ft.length = r_cnt;
            end
            M_QUOTE: begin
                ft_v = 1'b1;
                if (r_qs && r_cnt == 16'd1) begin
                    ft     = mk_tok(K_CHAR, 16'(r_begin));
                    ft.chv = r_first;
                end else begin
                    ft        = mk_tok(K_STRING, 16'(r_begin));
                    ft.length = r_cnt;
                end
            end
            M_INT, M_FRAC, M_ESTART, M_ESIGN, M_EXP: begin
                ft_v   = 1'b1;
                ft     = mk_tok(K_NUMBER, 16'(r_begin));
                ft.sig = 64'(r_acc);
                ft.ovf = r_sat;
                if (w_dx > 13'sd1023) begin
                    ft.dexp = 11'sd1023;
                    ft.ovf  = 1'b1;
                end else if (w_dx < -13'sd1024) begin
                    ft.dexp = -11'sd1024;
                    ft.ovf  = 1'b1;
                end else begin
                    ft.dexp = w_dx[10:0];
                end
            end
            default: ft_v = 1'b0;
        endcase
    end

    // two-character punctuation
    always_comb begin
        w_pair = '0;
        case (r_pend)
            C_GT: w_pair = (r_c == C_EQ) ? K_GTEQ : (r_c == C_GT) ? K_GT2 : 5'd0;
            C_LT: w_pair = (r_c == C_EQ) ? K_LTEQ : (r_c == C_LT) ? K_LT2 : 5'd0;
            C_EXC: w_pair = (r_c == C_EQ) ? K_NEQ : 5'd0;
            C_EQ: w_pair = (r_c == C_EQ) ? K_EQ2 : 5'd0;
            default: w_pair = '0;
        endcase
    end

    // next state and produced tokens for the registered byte
    always_comb begin
        logic   do_flush, do_idle;
        t_token t;
        do_flush = 1'b0;
        do_idle  = 1'b0;
        t        = '0;
        n_mode = r_mode; n_pend = r_pend; n_pos = r_pos; n_begin = r_begin;
        n_wb = r_wb; n_cnt = r_cnt; n_acc = r_acc; n_frac = r_frac;
        n_exp = r_exp; n_neg = r_neg; n_qs = r_qs; n_sat = r_sat; n_first = r_first;
        push = '0;

        if (r_c == 8'd0) begin
            // end of source
            do_flush = 1'b1;
            n_mode   = M_IDLE;
            n_pos    = '0;
        end else begin
            n_pos = r_pos + PB'(1);
            case (r_mode)
                M_PUNCT: begin
                    if (r_pend == C_SLASH && r_c == C_SLASH) begin
                        n_mode = M_COMMENT;
                    end else if (r_pend == C_DOT && w_digit) begin
                        n_acc  = SB'(w_d);
                        n_frac = 8'd1;
                        n_exp  = '0;
                        n_neg  = 1'b0;
                        n_sat  = 1'b0;
                        n_mode = M_FRAC;
                    end else if (w_pair != 5'd0) begin
                        push.cnt  = 2'd1;
                        push.tok0 = mk_tok(w_pair, 16'(r_begin));
                        n_mode    = M_IDLE;
                    end else begin
                        do_flush = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (r_c == C_NL) n_mode = M_IDLE;
                end
                M_IDENT: begin
                    if (w_alpha || w_digit || r_c == C_UNDER) begin
                        for (int k = 0; k < KEYWORD_BYTES; k++) begin
                            if (r_cnt == 16'(k)) n_wb[k] = r_c;
                        end
                        if (r_cnt != 16'hFFFF) n_cnt = r_cnt + 16'd1;
                    end else begin
                        do_flush = 1'b1;
                    end
                end
                M_QUOTE: begin
                    if (r_c == (r_qs ? C_SQUOTE : C_DQUOTE)) begin
                        push.cnt  = 2'd1;
                        push.tok0 = ft;
                        n_mode    = M_IDLE;
                    end else begin
                        if (r_cnt == 16'd0) n_first = r_c;
                        if (r_cnt != 16'hFFFF) n_cnt = r_cnt + 16'd1;
                    end
                end
                M_INT: begin
                    if (w_digit) begin
                        n_acc = w_acc_next;
                        n_sat = r_sat | w_acc_ovf;
                    end else if (r_c == C_DOT) begin
                        n_mode = M_FRAC;
                    end else begin
                        do_flush = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (w_digit) begin
                        n_acc = w_acc_next;
                        n_sat = r_sat | w_acc_ovf | (r_frac == 8'hFF);
                        if (r_frac != 8'hFF) n_frac = r_frac + 8'd1;
                    end else if (r_c == C_LE || r_c == C_UE) begin
                        n_mode = M_ESTART;
                    end else begin
                        do_flush = 1'b1;
                    end
                end
                M_ESTART: begin
                    if (r_c == C_PLUS || r_c == C_MINUS) begin
                        n_neg  = (r_c == C_MINUS);
                        n_mode = M_ESIGN;
                    end else if (w_digit) begin
                        n_exp  = w_exp_next;
                        n_mode = M_EXP;
                    end else begin
                        do_flush = 1'b1;
                    end
                end
                M_ESIGN, M_EXP: begin
                    if (w_digit) begin
                        n_exp  = w_exp_next;
                        n_mode = M_EXP;
                    end else begin
                        do_flush = 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase
            if (do_flush) do_idle = 1'b1;
        end

        // held token goes first
        if (do_flush && ft_v) begin
            push.cnt  = 2'd1;
            push.tok0 = ft;
        end
        if (do_flush) n_mode = M_IDLE;

        // end token after the last source
        if (r_c == 8'd0 && r_fin) begin
            t = mk_tok(K_END, w_cur16);
            if (push.cnt == 2'd0) push.tok0 = t;
            else push.tok1 = t;
            push.cnt = push.cnt + 2'd1;
        end

        // byte seen from idle
        if (do_idle) begin
            n_mode = M_IDLE;
            t      = '0;
            if (w_space) begin
                n_mode = M_IDLE;
            end else if (w_digit) begin
                n_begin = r_pos;
                n_acc   = SB'(w_d);
                n_frac  = '0;
                n_exp   = '0;
                n_neg   = 1'b0;
                n_sat   = 1'b0;
                n_mode  = M_INT;
            end else begin
                case (r_c)
                    C_PLUS:  t = mk_tok(K_PLUS, w_cur16);
                    C_MINUS: t = mk_tok(K_MINUS, w_cur16);
                    C_STAR:  t = mk_tok(K_STAR, w_cur16);
                    C_COMMA: t = mk_tok(K_COMMA, w_cur16);
                    C_SEMI:  t = mk_tok(K_SEMI, w_cur16);
                    C_SLASH, C_DOT, C_GT, C_LT, C_EXC, C_EQ: begin
                        n_pend  = r_c;
                        n_begin = r_pos;
                        n_mode  = M_PUNCT;
                    end
                    C_SQUOTE, C_DQUOTE: begin
                        n_qs    = (r_c == C_SQUOTE);
                        n_begin = r_pos + PB'(1);
                        n_cnt   = '0;
                        n_first = '0;
                        n_mode  = M_QUOTE;
                    end
                    default: begin
                        if (w_alpha || r_c == C_UNDER) begin
                            for (int k = 0; k < KEYWORD_BYTES; k++) n_wb[k] = '0;
                            n_wb[0] = r_c;
                            n_cnt   = 16'd1;
                            n_begin = r_pos;
                            n_mode  = M_IDENT;
                        end
                    end
                endcase
                if (r_c == C_PLUS || r_c == C_MINUS || r_c == C_STAR ||
                    r_c == C_COMMA || r_c == C_SEMI) begin
                    if (push.cnt == 2'd0) push.tok0 = t;
                    else push.tok1 = t;
                    push.cnt = push.cnt + 2'd1;
                end
            end
        end

        // mark the final token of this byte
        if (push.cnt == 2'd1) push.tok0.last = 1'b1;
        if (push.cnt == 2'd2) push.tok1.last = 1'b1;
        if (!fire) push.cnt = 2'd0;
    end

    assign o_push = push;

    // input register and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_mode   <= M_IDLE;
            r_pend   <= '0;
            r_pos    <= '0;
            r_begin  <= '0;
            r_cnt    <= '0;
            r_acc    <= '0;
            r_frac   <= '0;
            r_exp    <= '0;
            r_neg    <= 1'b0;
            r_qs     <= 1'b0;
            r_sat    <= 1'b0;
            r_first  <= '0;
            for (int k = 0; k < KEYWORD_BYTES; k++) r_wb[k] <= '0;
        end else begin
            if (o_in_ready) r_in_vld <= i_in_valid;
            if (fire) begin
                r_mode  <= n_mode;
                r_pend  <= n_pend;
                r_pos   <= n_pos;
                r_begin <= n_begin;
                r_wb    <= n_wb;
                r_cnt   <= n_cnt;
                r_acc   <= n_acc;
                r_frac  <= n_frac;
                r_exp   <= n_exp;
                r_neg   <= n_neg;
                r_qs    <= n_qs;
                r_sat   <= n_sat;
                r_first <= n_first;
            end
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_c   <= i_char_code;
            r_fin <= i_final_source;
        end
    end

endmodule

FILE: sv/stx_outq.sv
// result queue: takes up to two tokens per cycle, hands out one while the reader is ready
// depends on stx_pkg
module stx_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stx_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output stx_pkg::t_token o_tok
);
    import stx_pkg::*;

    localparam int AW = $clog2(Q_DEPTH);

    t_token        r_mem [Q_DEPTH];
    logic [AW-1:0] r_head, r_tail;
    logic [AW:0]   r_count;
    logic          pop;

    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_head];
    assign pop     = o_valid & i_ready;
    // room for two more tokens regardless of a pop this cycle
    assign o_room  = (r_count <= (AW+1)'(Q_DEPTH - 2));

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= r_head + AW'(pop);
            r_tail  <= r_tail + AW'(i_push.cnt);
            r_count <= r_count + (AW+1)'(i_push.cnt) - (AW+1)'(pop);
        end
    end

    // token storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_tail] <= i_push.tok0;
        if (i_push.cnt == 2'd2) r_mem[r_tail + AW'(1)] <= i_push.tok1;
    end

endmodule

FILE: sv/source_text_lexer.sv
// top level of the source text lexer: byte input, token output
// depends on stx_pkg, stx_core, stx_outq
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_char_code, i_final_source
//  out     | output    | o_out_valid / i_out_ready  | o_token_kind ... o_last_of_run
//
// one byte per cycle enters; it is registered, decoded combinationally and its
// zero to two tokens go into a four-entry result queue
// output drains one token per cycle while i_out_ready is high, so bytes that
// close one token and open another limit the sustained rate to the token rate
// input stalls only while the queue lacks room for two tokens
// reset is synchronous, active low, and clears scan state and the queue
module source_text_lexer #(
    parameter int POSITION_BITS    = 16,
    parameter int SIGNIFICAND_BITS = 64,
    parameter int KEYWORD_BYTES    = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_code,
    input  logic               i_final_source,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [4:0]         o_token_kind,
    output logic [15:0]        o_token_start,
    output logic [15:0]        o_token_length,
    output logic [63:0]        o_significand,
    output logic signed [10:0] o_decimal_exponent,
    output logic [7:0]         o_char_value,
    output logic               o_number_overflow,
    output logic               o_last_of_run
);
    import stx_pkg::*;

    t_push  push;
    t_token tok;
    logic   room;

    // scan logic
    stx_core #(
        .POSITION_BITS   (POSITION_BITS),
        .SIGNIFICAND_BITS(SIGNIFICAND_BITS),
        .KEYWORD_BYTES   (KEYWORD_BYTES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_code   (i_char_code),
        .i_final_source(i_final_source),
        .i_room        (room),
        .o_push        (push)
    );

    // result queue
    stx_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_room (room),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_tok  (tok)
    );

    assign o_token_kind       = tok.kind;
    assign o_token_start      = tok.start;
    assign o_token_length     = tok.length;
    assign o_significand      = tok.sig;
    assign o_decimal_exponent = tok.dexp;
    assign o_char_value       = tok.chv;
    assign o_number_overflow  = tok.ovf;
    assign o_last_of_run      = tok.last;

endmodule

FILE: sv/stx_checker.sv
// port-level checks of the source text lexer, bound to the top level
// depends on stx_pkg and source_text_lexer_macros.svh
`include "source_text_lexer_macros.svh"

module stx_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [4:0]         o_token_kind,
    input logic [63:0]        o_significand,
    input logic [7:0]         o_char_value,
    input logic               o_number_overflow,
    input logic signed [10:0] o_decimal_exponent
);
    import stx_pkg::*;

    // a stalled transaction stays offered
    `STX_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // number fields are zero on other kinds
    `STX_ASSERT_IMP(a_num_fields, i_clk, i_rst_n, o_out_valid && o_token_kind != K_NUMBER, o_significand == 64'd0 && o_number_overflow == 1'b0 && o_decimal_exponent == 11'sd0)

    // char value only on char tokens
    `STX_ASSERT_IMP(a_char_field, i_clk, i_rst_n, o_out_valid && o_token_kind != K_CHAR, o_char_value == 8'd0)

    // no kind code past the end token
    `STX_ASSERT_IMP(a_kind_range, i_clk, i_rst_n, o_out_valid, o_token_kind <= K_END)

endmodule

bind source_text_lexer stx_checker u_stx_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_token_kind      (o_token_kind),
    .o_significand     (o_significand),
    .o_char_value      (o_char_value),
    .o_number_overflow (o_number_overflow),
    .o_decimal_exponent(o_decimal_exponent)
);

FILE: sim/source_text_lexer_tb.sv
// self-checking testbench of the source text lexer: byte stream in, tokens out
// depends on stx_pkg and source_text_lexer
module source_text_lexer_tb;
    import stx_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PUNCT, S_COMMENT, S_IDENT, S_QUOTE, S_INT, S_FRAC, S_ESTART, S_ESIGN, S_EXP
    } t_scan;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [63:0] sig;
        logic [10:0] dexp;
        logic [7:0]  chv;
        logic        ovf;
        logic        last;
    } t_exp_tok;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_src_byte;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [63:0] SIG_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready, i_final_source;
    logic [7:0] i_char_code;
    logic o_out_valid, i_out_ready;
    logic [4:0] o_token_kind;
    logic [15:0] o_token_start, o_token_length;
    logic [63:0] o_significand;
    logic signed [10:0] o_decimal_exponent;
    logic [7:0] o_char_value;
    logic o_number_overflow, o_last_of_run;

    source_text_lexer u_dut (.*);

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // lexer state mirror
    t_scan       mode;
    logic [7:0]  held_punct;
    logic [15:0] pos;
    logic [15:0] tok_begin;
    logic [63:0] word_text;
    logic [15:0] word_len;
    logic [63:0] digits;
    logic [7:0]  frac_cnt;
    logic [10:0] exp_mag;
    logic        exp_neg;
    logic        is_single;
    logic [7:0]  first_byte;
    logic        saturated;

    t_exp_tok expected_tokens[$];
    t_exp_tok step_tokens[$];
    t_src_byte src_queue[$];
    int mismatches;
    int accepted_bytes;

    function automatic bit is_digit(logic [7:0] c);
        return c >= C_ZERO && c <= C_NINE;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= C_LA && c <= C_LZ) || (c >= C_UA && c <= C_UZ);
    endfunction

    function automatic void add_token(logic [4:0] kind, logic [15:0] start,
                                      logic [15:0] len = 0, logic [63:0] sig = 0,
                                      logic [10:0] dexp = 0, logic [7:0] chv = 0,
                                      logic ovf = 0);
        t_exp_tok t;
        t = '{kind, start, len, sig, dexp, chv, ovf, 1'b0};
        if (step_tokens.size() < 3) step_tokens.push_back(t);
    endfunction

    function automatic void begin_number(logic [15:0] b);
        tok_begin = b;
        digits = 0;
        frac_cnt = 0;
        exp_mag = 0;
        exp_neg = 0;
        saturated = 0;
    endfunction

    function automatic void accumulate_digit(logic [7:0] c, bit frac);
        logic [63:0] d;
        d = 64'(c - C_ZERO);
        if (digits > (SIG_MAX - d) / 10) begin
            digits = SIG_MAX;
            saturated = 1;
        end else begin
            digits = digits * 10 + d;
        end
        if (frac) begin
            if (frac_cnt == 8'd255) saturated = 1;
            else frac_cnt++;
        end
    endfunction

    function automatic void accumulate_exp(logic [7:0] c);
        int v;
        v = int'(exp_mag) * 10 + int'(c - C_ZERO);
        exp_mag = (v > 2047) ? 11'd2047 : 11'(v);
    endfunction

    function automatic void close_number();
        int e;
        logic ovf;
        e = exp_neg ? -int'(exp_mag) : int'(exp_mag);
        e = e - int'(frac_cnt);
        ovf = saturated;
        if (e > 1023) begin
            e = 1023;
            ovf = 1;
        end
        if (e < -1024) begin
            e = -1024;
            ovf = 1;
        end
        add_token(K_NUMBER, tok_begin, 0, digits, 11'(e), 0, ovf);
    endfunction

    function automatic void close_word();
        logic [4:0] k;
        k = K_IDENT;
        for (int i = NUM_KW - 1; i >= 0; i--) begin
            if (word_len == KW_LEN[i] && word_text == KW_TEXT[i]) k = K_KEYWORD0 + 5'(i);
        end
        add_token(k, tok_begin, word_len);
    endfunction

    function automatic void close_quote();
        if (is_single && word_len == 1) add_token(K_CHAR, tok_begin, 0, 0, 0, first_byte);
        else add_token(K_STRING, tok_begin, word_len);
    endfunction

    function automatic logic [4:0] lone_punct(logic [7:0] p);
        case (p)
            C_SLASH: return K_SLASH;
            C_DOT:   return K_DOT;
            C_GT:    return K_GT;
            C_LT:    return K_LT;
            C_EXC:   return K_EXC;
            default: return K_EQ;
        endcase
    endfunction

    function automatic void close_held();
        case (mode)
            S_PUNCT: add_token(lone_punct(held_punct), tok_begin);
            S_IDENT: close_word();
            S_QUOTE: close_quote();
            S_INT, S_FRAC, S_ESTART, S_ESIGN, S_EXP: close_number();
            default: ;
        endcase
        mode = S_IDLE;
    endfunction

    function automatic void start_token(logic [7:0] c, logic [15:0] cur);
        mode = S_IDLE;
        if (c == C_SPACE || (c >= C_TAB && c <= C_CR)) return;
        if (is_digit(c)) begin
            begin_number(cur);
            accumulate_digit(c, 0);
            mode = S_INT;
            return;
        end
        case (c)
            C_PLUS:  add_token(K_PLUS, cur);
            C_MINUS: add_token(K_MINUS, cur);
            C_STAR:  add_token(K_STAR, cur);
            C_COMMA: add_token(K_COMMA, cur);
            C_SEMI:  add_token(K_SEMI, cur);
            C_SLASH, C_DOT, C_GT, C_LT, C_EXC, C_EQ: begin
                held_punct = c;
                tok_begin = cur;
                mode = S_PUNCT;
            end
            C_SQUOTE, C_DQUOTE: begin
                is_single = (c == C_SQUOTE);
                tok_begin = cur + 16'd1;
                word_len = 0;
                first_byte = 0;
                mode = S_QUOTE;
            end
            default: begin
                if (is_alpha(c) || c == C_UNDER) begin
                    word_text = {56'd0, c};
                    word_len = 1;
                    tok_begin = cur;
                    mode = S_IDENT;
                end
            end
        endcase
    endfunction

    // two-character punctuation, returns 1 when the pair was formed
    function automatic bit pair_punct(logic [7:0] c);
        logic [4:0] k;
        bit hit;
        hit = 1;
        if (held_punct == C_GT && c == C_EQ) k = K_GTEQ;
        else if (held_punct == C_GT && c == C_GT) k = K_GT2;
        else if (held_punct == C_LT && c == C_EQ) k = K_LTEQ;
        else if (held_punct == C_LT && c == C_LT) k = K_LT2;
        else if (held_punct == C_EXC && c == C_EQ) k = K_NEQ;
        else if (held_punct == C_EQ && c == C_EQ) k = K_EQ2;
        else hit = 0;
        if (hit) begin
            add_token(k, tok_begin);
            mode = S_IDLE;
        end
        return hit;
    endfunction

    function automatic void scan_byte(logic [7:0] c, logic [15:0] cur);
        case (mode)
            S_PUNCT: begin
                if (held_punct == C_SLASH && c == C_SLASH) begin
                    mode = S_COMMENT;
                    return;
                end
                if (held_punct == C_DOT && is_digit(c)) begin
                    begin_number(tok_begin);
                    accumulate_digit(c, 1);
                    mode = S_FRAC;
                    return;
                end
                if (pair_punct(c)) return;
            end
            S_COMMENT: begin
                if (c == C_NL) mode = S_IDLE;
                return;
            end
            S_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == C_UNDER) begin
                    if (word_len < 8) word_text[word_len*8 +: 8] = c;
                    if (word_len != 16'hFFFF) word_len++;
                    return;
                end
            end
            S_QUOTE: begin
                if (c == (is_single ? C_SQUOTE : C_DQUOTE)) begin
                    close_quote();
                    mode = S_IDLE;
                    return;
                end
                if (word_len == 0) first_byte = c;
                if (word_len != 16'hFFFF) word_len++;
                return;
            end
            S_INT: begin
                if (is_digit(c)) begin
                    accumulate_digit(c, 0);
                    return;
                end
                if (c == C_DOT) begin
                    mode = S_FRAC;
                    return;
                end
            end
            S_FRAC: begin
                if (is_digit(c)) begin
                    accumulate_digit(c, 1);
                    return;
                end
                if (c == C_LE || c == C_UE) begin
                    mode = S_ESTART;
                    return;
                end
            end
            S_ESTART: begin
                if (c == C_PLUS || c == C_MINUS) begin
                    exp_neg = (c == C_MINUS);
                    mode = S_ESIGN;
                    return;
                end
                if (is_digit(c)) begin
                    accumulate_exp(c);
                    mode = S_EXP;
                    return;
                end
            end
            S_ESIGN, S_EXP: begin
                if (is_digit(c)) begin
                    accumulate_exp(c);
                    mode = S_EXP;
                    return;
                end
            end
            default: begin
                start_token(c, cur);
                return;
            end
        endcase
        close_held();
        start_token(c, cur);
    endfunction

    // expected tokens of one accepted byte
    function automatic void predict_tokens(t_src_byte b);
        step_tokens.delete();
        if (b.ch == 8'd0) begin
            close_held();
            if (b.fin) add_token(K_END, pos);
            pos = 0;
        end else begin
            scan_byte(b.ch, pos);
            pos = pos + 16'd1;
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    // idle pattern, changes every 128 accepted bytes
    function automatic bit idle_now(bit receiver);
        int ph;
        ph = (accepted_bytes / 128) % 4;
        case (ph)
            1: return receiver ? 0 : ($urandom_range(0, 99) < 64);
            2: return receiver ? ($urandom_range(0, 99) < 64) : 0;
            3: return $urandom_range(0, 99) < 6;
            default: return 0;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_char_code <= 8'd0;
            i_final_source <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_tokens('{i_char_code, i_final_source});
                accepted_bytes++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (src_queue.size() > 0 && !idle_now(0)) begin
                    t_src_byte b;
                    b = src_queue.pop_front();
                    i_char_code <= b.ch;
                    i_final_source <= b.fin;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each output transaction against the oldest expected token
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                t_exp_tok got, exp_tok;
                got = '{o_token_kind, o_token_start, o_token_length, o_significand,
                        o_decimal_exponent, o_char_value, o_number_overflow, o_last_of_run};
                if (expected_tokens.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected token: kind %0d start %0d", got.kind, got.start);
                end else begin
                    exp_tok = expected_tokens.pop_front();
                    if (got !== exp_tok) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("token mismatch: expected %p, got %p", exp_tok, got);
                    end
                end
            end
            i_out_ready <= !idle_now(1);
        end
    end

    // watchdog on cycles with no transaction
    int quiet_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) src_queue.push_back('{s[i], 1'b0});
    endtask

    task automatic put_end(bit fin);
        src_queue.push_back('{8'd0, fin});
    endtask

    task automatic put_digits(int n);
        for (int i = 0; i < n; i++) src_queue.push_back('{8'(C_ZERO + $urandom_range(0, 9)), 1'b0});
    endtask

    task automatic put_word_tail(int n);
        string pool;
        pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        for (int i = 0; i < n; i++)
            src_queue.push_back('{pool[$urandom_range(0, pool.len() - 1)], 1'b0});
    endtask

    // one random lexeme, mostly well formed
    task automatic put_lexeme();
        string keywords[8];
        string puncts;
        keywords = '{"return", "func", "get", "if", "else", "while", "break", "continue"};
        puncts = "+-*/.,;><!=";
        case ($urandom_range(0, 11))
            0: put_text(keywords[$urandom_range(0, 7)]);
            1: begin
                put_text($urandom_range(0, 1) ? "_" : "q");
                put_word_tail($urandom_range(0, 10));
            end
            2, 3: begin
                put_digits($urandom_range(1, 3) == 1 ? $urandom_range(18, 24) : $urandom_range(1, 4));
                if ($urandom_range(0, 2) != 0) begin
                    put_text(".");
                    put_digits($urandom_range(0, 4));
                    if ($urandom_range(0, 1)) begin
                        put_text($urandom_range(0, 1) ? "e" : "E");
                        case ($urandom_range(0, 2))
                            0: put_text("+");
                            1: put_text("-");
                            default: ;
                        endcase
                        put_digits($urandom_range(0, 5));
                    end
                end
            end
            4: begin
                put_text(".");
                put_digits($urandom_range(1, 3));
            end
            5: for (int i = $urandom_range(1, 2); i > 0; i--)
                put_text(puncts.substr($urandom_range(0, 10), 0) == "" ? "+" :
                         puncts.substr($urandom_range(0, 10), $urandom_range(0, 10)));
            6: begin
                bit sq;
                sq = $urandom_range(0, 1);
                put_text(sq ? "'" : "\"");
                for (int i = $urandom_range(0, 3); i > 0; i--)
                    src_queue.push_back('{8'($urandom_range(1, 255)), 1'b0});
                if ($urandom_range(0, 4) != 0) put_text(sq ? "'" : "\"");
            end
            7: begin
                put_text("//");
                for (int i = $urandom_range(0, 5); i > 0; i--)
                    src_queue.push_back('{8'($urandom_range(1, 255)), 1'b0});
                put_text("\n");
            end
            8: src_queue.push_back('{8'($urandom_range(1, 255)), 1'b0});
            9: put_end($urandom_range(0, 1));
            default: put_text($urandom_range(0, 1) ? " " : "\t\r\n");
        endcase
        if ($urandom_range(0, 2) != 0) put_text(" ");
    endtask

    // stimulus and end of run
    initial begin
        mode = S_IDLE;
        held_punct = 0;
        pos = 0;
        tok_begin = 0;
        word_text = 0;
        word_len = 0;
        digits = 0;
        frac_cnt = 0;
        exp_mag = 0;
        exp_neg = 0;
        is_single = 0;
        first_byte = 0;
        saturated = 0;
        mismatches = 0;
        accepted_bytes = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_char_code = 8'd0;
        i_final_source = 1'b0;
        i_out_ready = 1'b0;

        // directed: keywords, punctuation, quotes, numbers, comments, odd bytes
        put_text("return func get if else while break continue whil x_9 ");
        put_text(">=>><=<<!===> < ! = / . +-*,;");
        put_text("// note\n'a' 'ab' '' \"str\" ");
        put_text("12.5e-3 1. .5 1e5 3.E+ 7.e-2000 1.5e99999 ");
        put_text("99999999999999999999999 (");
        src_queue.push_back('{8'hFF, 1'b0});
        put_text("\"open");
        put_end(1'b0);
        put_text("'z");
        put_end(1'b1);
        put_text("ab>");
        put_end(1'b1);

        // saturated fraction count
        put_text("0.");
        put_digits(258);
        put_end(1'b0);

        // random lexemes
        while (src_queue.size() < 520) put_lexeme();
        put_end(1'b1);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (src_queue.size() != 0 || i_in_valid || expected_tokens.size() != 0);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
